// ----- rtl/core/sdx_pkg.sv -----
// package for the soundex encoder: character classes, run phases, result type
// no dependencies; used by sdx_classify, sdx_state and soundex_encoder_core
`default_nettype none

package sdx_pkg;

  // code position: initial pending, then digit slots one to three, then full
  localparam logic [2:0] POS_INIT       = 3'd0;
  localparam logic [2:0] POS_FIRST      = 3'd1;
  localparam logic [2:0] POS_DIGIT_LAST = 3'd3;

  // letter group code of a byte that belongs to no group
  localparam logic [2:0] GRP_NONE = 3'd0;

  // state of the merge logic for runs of one group
  typedef enum logic [1:0] {
    PH_NONE,
    PH_RUN,
    PH_BRIDGE,
    PH_RUN2
  } sdx_phase_t;

  // byte classification, computed at the input and carried in the input register
  typedef struct packed {
    logic [7:0] upper;
    logic       is_nul;
    logic [2:0] group;
    logic       bridge;
    logic       skipped;
  } sdx_class_t;

  // one finished code
  typedef struct packed {
    logic [7:0] initial_char;
    logic [2:0] digit_one;
    logic [2:0] digit_two;
    logic [2:0] digit_three;
  } sdx_result_t;

  // a-z to upper case, anything else unchanged
  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] u;
    u = c;
    if (c >= "a" && c <= "z") begin
      u = c - 8'd32;
    end
    return u;
  endfunction

  // letter group of an upper-cased byte
  function automatic logic [2:0] group_of(input logic [7:0] u);
    logic [2:0] g;
    case (u)
      "B", "F", "P", "V": g = 3'd1;
      "C", "G", "J", "K", "Q", "S", "X", "Z": g = 3'd2;
      "D", "T": g = 3'd3;
      "L": g = 3'd4;
      "M", "N": g = 3'd5;
      "R": g = 3'd6;
      default: g = GRP_NONE;
    endcase
    return g;
  endfunction

  // vowels, y, h, w and apostrophe take no code slot
  function automatic logic is_skipped(input logic [7:0] u);
    logic s;
    case (u)
      "A", "E", "I", "O", "U", "W", "Y", "H", "'": s = 1'b1;
      default: s = 1'b0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sdx_channels.sv -----
// valid/ready channel interfaces for the soundex encoder input and result
// no dependencies
`default_nettype none

// name bytes, one per transaction
interface sdx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

// finished codes, one per transaction
interface sdx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] initial_char;
  logic [2:0] digit_one;
  logic [2:0] digit_two;
  logic [2:0] digit_three;

  modport source (output valid, output initial_char, output digit_one,
                  output digit_two, output digit_three, input ready);
  modport sink   (input valid, input initial_char, input digit_one,
                  input digit_two, input digit_three, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sdx_classify.sv -----
// byte classifier: upper case, letter group, bridge and skip flags
// depends on sdx_pkg
`default_nettype none

module sdx_classify (
  input  wire logic [7:0]         ch,
  output sdx_pkg::sdx_class_t     cls
);

  logic [7:0] upper;

  // fold case once, then decode
  assign upper = sdx_pkg::to_upper(ch);

  always_comb begin
    cls.upper   = upper;
    cls.is_nul  = (ch == 8'd0);
    cls.group   = sdx_pkg::group_of(upper);
    cls.bridge  = (upper == "H") || (upper == "W");
    cls.skipped = sdx_pkg::is_skipped(upper);
  end

endmodule

`default_nettype wire

// ----- rtl/core/sdx_state.sv -----
// per-name encoder state: initial, code digits, run merge and terminator tracking
// depends on sdx_pkg
`default_nettype none

module sdx_state (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 upd,
  input  wire logic                 last,
  input  wire sdx_pkg::sdx_class_t  cls,
  output sdx_pkg::sdx_result_t      res
);

  logic [2:0]          pos_r,   pos_nxt;
  sdx_pkg::sdx_phase_t phase_r, phase_nxt;
  logic [2:0]          grp_r,   grp_nxt;
  logic                term_r,  term_nxt;
  logic [7:0]          first_r, first_nxt;
  logic [2:0]          dig0_r,  dig0_nxt;
  logic [2:0]          dig1_r,  dig1_nxt;
  logic [2:0]          dig2_r,  dig2_nxt;
  logic                fresh;

  // next state for one byte
  always_comb begin
    pos_nxt   = pos_r;
    phase_nxt = phase_r;
    grp_nxt   = grp_r;
    term_nxt  = term_r;
    first_nxt = first_r;
    dig0_nxt  = dig0_r;
    dig1_nxt  = dig1_r;
    dig2_nxt  = dig2_r;
    fresh     = 1'b0;
    if (!term_r) begin
      if (cls.is_nul) begin
        term_nxt = 1'b1;
      end else if (pos_r == sdx_pkg::POS_INIT) begin
        // initial byte opens a run if it has a group
        first_nxt = cls.upper;
        pos_nxt   = sdx_pkg::POS_FIRST;
        if (cls.group != sdx_pkg::GRP_NONE) begin
          grp_nxt   = cls.group;
          phase_nxt = sdx_pkg::PH_RUN;
        end else begin
          phase_nxt = sdx_pkg::PH_NONE;
        end
      end else if (pos_r <= sdx_pkg::POS_DIGIT_LAST) begin
        // merge same group, also across one stretch of h/w bytes
        fresh = 1'b1;
        case (phase_r)
          sdx_pkg::PH_RUN: begin
            if (cls.group == grp_r) begin
              fresh = 1'b0;
            end else if (cls.bridge) begin
              phase_nxt = sdx_pkg::PH_BRIDGE;
              fresh     = 1'b0;
            end
          end
          sdx_pkg::PH_BRIDGE: begin
            if (cls.bridge) begin
              fresh = 1'b0;
            end else if (cls.group == grp_r) begin
              phase_nxt = sdx_pkg::PH_RUN2;
              fresh     = 1'b0;
            end
          end
          sdx_pkg::PH_RUN2: begin
            if (cls.group == grp_r) begin
              fresh = 1'b0;
            end
          end
          default: begin
          end
        endcase
        // byte not absorbed: close the run and, unless skipped, fill the next digit slot
        if (fresh) begin
          phase_nxt = sdx_pkg::PH_NONE;
          if (!cls.skipped) begin
            case (pos_r[1:0])
              2'd1:    dig0_nxt = cls.group;
              2'd2:    dig1_nxt = cls.group;
              2'd3:    dig2_nxt = cls.group;
              default: begin
              end
            endcase
            pos_nxt = pos_r + 3'd1;
            if (cls.group != sdx_pkg::GRP_NONE) begin
              grp_nxt   = cls.group;
              phase_nxt = sdx_pkg::PH_RUN;
            end
          end
        end
      end
    end
  end

  // state registers, cleared on reset and after the closing byte of a name
  always_ff @(posedge clk) begin
    if (!rst_n || (upd && last)) begin
      pos_r   <= sdx_pkg::POS_INIT;
      phase_r <= sdx_pkg::PH_NONE;
      grp_r   <= sdx_pkg::GRP_NONE;
      term_r  <= 1'b0;
      first_r <= 8'd0;
      dig0_r  <= 3'd0;
      dig1_r  <= 3'd0;
      dig2_r  <= 3'd0;
    end else if (upd) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      grp_r   <= grp_nxt;
      term_r  <= term_nxt;
      first_r <= first_nxt;
      dig0_r  <= dig0_nxt;
      dig1_r  <= dig1_nxt;
      dig2_r  <= dig2_nxt;
    end
  end

  // code as it stands after this byte
  always_comb begin
    res.initial_char = first_nxt;
    res.digit_one    = dig0_nxt;
    res.digit_two    = dig1_nxt;
    res.digit_three  = dig2_nxt;
  end

  // position never runs past the full code
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= 3'd4)
    else $error("code position out of range");

  // an open run always has a real group
  a_run_group: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != sdx_pkg::PH_NONE) |-> (grp_r != sdx_pkg::GRP_NONE))
    else $error("run open without a group");

  // closing byte leaves the state ready for a new name
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (upd && last) |=> (pos_r == sdx_pkg::POS_INIT && !term_r
                       && phase_r == sdx_pkg::PH_NONE))
    else $error("state not cleared after name end");

endmodule

`default_nettype wire

// ----- rtl/core/soundex_encoder_core.sv -----
// soundex encoder top level: input register, encoder state, result register
// depends on sdx_pkg, sdx_channels (sdx_in_if, sdx_out_if), sdx_classify, sdx_state
//
// usage:
//   in_if carries one name byte per transaction (ch) with last marking the
//   closing byte. a zero byte ends the name early; bytes after it, and bytes
//   after the third digit is filled, are dropped until last.
//   out_if carries one code per name: initial_char and three digits 0..6,
//   produced only for the transaction with last set.
//   path: a closing byte goes from the input register to the result register
//   once that register is free. throughput: one byte per cycle unless stalled,
//   set by the single pass from the input register through the state update.
//   stall: a full result register held by out_if.ready low blocks only the
//   next closing byte; other bytes keep flowing. in_if.ready falls when the
//   input register holds such a byte.
//   reset: rst_n low clears both registers' valid flags and the encoder state,
//   so the next byte is taken as the initial of a new name.
`default_nettype none

module soundex_encoder_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sdx_in_if.sink     in_if,
  sdx_out_if.source  out_if
);

  sdx_pkg::sdx_class_t  in_cls;
  sdx_pkg::sdx_class_t  s1_cls_r;
  logic                 s1_last_r;
  logic                 s1_valid_r, s1_valid_nxt;
  logic                 s1_adv;
  logic                 in_take;
  sdx_pkg::sdx_result_t res;
  sdx_pkg::sdx_result_t out_res_r;
  logic                 out_valid_r, out_valid_nxt;

  // classify the byte on the way in
  sdx_classify u_classify (
    .ch  (in_if.ch),
    .cls (in_cls)
  );

  // input stage moves on unless it holds a closing byte and the result is blocked
  assign s1_adv       = s1_valid_r && (!s1_last_r || !out_valid_r || out_if.ready);
  assign in_if.ready  = !s1_valid_r || s1_adv;
  assign in_take      = in_if.valid && in_if.ready;
  assign s1_valid_nxt = in_take || (s1_valid_r && !s1_adv);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cls_r  <= in_cls;
      s1_last_r <= in_if.last;
    end
  end

  // encoder state update
  sdx_state u_state (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (s1_adv),
    .last  (s1_last_r),
    .cls   (s1_cls_r),
    .res   (res)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_if.ready;
    if (s1_adv && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.initial_char = out_res_r.initial_char;
  assign out_if.digit_one    = out_res_r.digit_one;
  assign out_if.digit_two    = out_res_r.digit_two;
  assign out_if.digit_three  = out_res_r.digit_three;

  // a new result only comes from a closing byte
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv && s1_last_r))
    else $error("result raised without a closing byte");

  // a closing byte never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_adv && s1_last_r && out_valid_r && !out_if.ready))
    else $error("pending result overwritten");

  // a held input byte is not lost while the stage is blocked
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_cls_r)
                                 && $stable(s1_last_r)))
    else $error("blocked input byte changed");

endmodule

`default_nettype wire
